FILE: src/brb_pkg.sv
// shared types and constants for the byte ring buffer
package brb_pkg;

  localparam int unsigned RING_DEPTH_DEF = 1024;
  localparam int unsigned RESERVE        = 16;
  localparam int unsigned MAX_BURST      = 8;
  localparam int unsigned NUM_LANES      = 8;
  localparam int unsigned LANE_W         = 3;
  localparam int unsigned CAP_W          = 10;
  localparam int unsigned CNT_W          = 4;
  localparam int unsigned DATA_W         = 64;
  localparam int unsigned CAP_RESET      = 1008;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_STATUS = 2'd3
  } op_e;

  typedef struct packed {
    logic [CNT_W-1:0]  done_count;
    logic              is_get;
    logic [LANE_W-1:0] rot;
    logic [CAP_W-1:0]  free_bytes;
    logic [CAP_W-1:0]  used_bytes;
    logic              is_empty;
    logic              is_full;
  } res_meta_t;

endpackage

FILE: src/brb_bank_mem.sv
// one byte-wide bank of the ring store, single port, registered read
module brb_bank_mem #(
  parameter int unsigned ROWS  = 128,
  parameter int unsigned ROW_W = 7
) (
  input  logic             clk_i,
  input  logic [ROW_W-1:0] addr_i,
  input  logic             we_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [ROWS];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/brb_ctrl.sv
// pointers, occupancy, capacity register and bank addressing
module brb_ctrl #(
  parameter int unsigned RING_DEPTH = brb_pkg::RING_DEPTH_DEF,
  parameter int unsigned PTR_W      = $clog2(RING_DEPTH),
  parameter int unsigned ROW_W      = PTR_W - brb_pkg::LANE_W
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    accept_i,
  input  logic [1:0]                              op_i,
  input  logic [brb_pkg::CNT_W-1:0]               byte_count_i,
  input  logic [brb_pkg::DATA_W-1:0]              write_data_i,
  input  logic                                    cfg_we_i,
  input  logic [brb_pkg::CAP_W-1:0]               cfg_wdata_i,
  output logic [ROW_W-1:0]                        lane_row_o [brb_pkg::NUM_LANES],
  output logic [brb_pkg::NUM_LANES-1:0]           lane_we_o,
  output logic [brb_pkg::NUM_LANES-1:0][7:0]      lane_wdata_o,
  output logic                                    lane_re_o,
  output logic                                    res_valid_o,
  output brb_pkg::res_meta_t                      res_meta_o
);

  localparam int unsigned CAP_LIM = RING_DEPTH - brb_pkg::RESERVE;
  localparam int unsigned CW      = brb_pkg::CAP_W;
  localparam int unsigned NW      = brb_pkg::CNT_W;
  localparam int unsigned LW      = brb_pkg::LANE_W;

  logic [PTR_W-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [CW-1:0]    used_q, used_d, cap_q, cap_d;
  logic [CW-1:0]    free_cur;
  logic [NW-1:0]    n_sat, get_n, done_d;
  logic             put_ok;
  brb_pkg::op_e     op;
  logic [PTR_W-1:0] base;
  logic             res_valid_q;
  brb_pkg::res_meta_t meta_q, meta_d;

  assign op       = brb_pkg::op_e'(op_i);
  assign n_sat    = (byte_count_i > NW'(brb_pkg::MAX_BURST)) ? NW'(brb_pkg::MAX_BURST)
                                                              : byte_count_i;
  assign free_cur = cap_q - used_q;
  assign put_ok   = CW'(n_sat) <= free_cur;
  assign get_n    = (CW'(n_sat) > used_q) ? NW'(used_q) : n_sat;

  // capacity saturated so the ring always fits the store
  assign cap_d = (32'(cfg_wdata_i) > CAP_LIM) ? CW'(CAP_LIM) : cfg_wdata_i;

  always_comb begin
    rp_d   = rp_q;
    wp_d   = wp_q;
    used_d = used_q;
    done_d = '0;
    unique case (op)
      brb_pkg::OP_PUT: begin
        if (put_ok) begin
          wp_d   = wp_q + PTR_W'(n_sat);
          used_d = used_q + CW'(n_sat);
          done_d = n_sat;
        end
      end
      brb_pkg::OP_GET: begin
        rp_d   = rp_q + PTR_W'(get_n);
        used_d = used_q - CW'(get_n);
        done_d = get_n;
      end
      brb_pkg::OP_FLUSH: begin
        rp_d   = wp_q;
        used_d = '0;
      end
      brb_pkg::OP_STATUS: begin
        done_d = '0;
      end
      default: begin
        done_d = '0;
      end
    endcase

    meta_d.done_count = done_d;
    meta_d.is_get     = (op == brb_pkg::OP_GET);
    meta_d.rot        = rp_q[LW-1:0];
    meta_d.free_bytes = cap_q - used_d;
    meta_d.used_bytes = used_d;
    meta_d.is_empty   = (used_d == '0);
    meta_d.is_full    = (cap_q == used_d);
  end

  // lane b holds byte (b - base) mod lanes of the burst; it sits one row on if it wrapped
  assign base      = (op == brb_pkg::OP_PUT) ? wp_q : rp_q;
  assign lane_re_o = accept_i && (op == brb_pkg::OP_GET);

  for (genvar b = 0; b < brb_pkg::NUM_LANES; b++) begin : g_lane
    logic [LW-1:0] off;
    assign off = LW'(b) - base[LW-1:0];
    assign lane_row_o[b] = base[PTR_W-1:LW] + ROW_W'(LW'(b) < base[LW-1:0]);
    assign lane_we_o[b]  = accept_i && (op == brb_pkg::OP_PUT) && put_ok &&
                           (NW'(off) < n_sat);
    assign lane_wdata_o[b] = write_data_i[{off, 3'b000} +: 8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= '0;
      wp_q        <= '0;
      used_q      <= '0;
      cap_q       <= (CAP_LIM < brb_pkg::CAP_RESET) ? CW'(CAP_LIM) : CW'(brb_pkg::CAP_RESET);
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= accept_i;
      if (cfg_we_i) begin
        cap_q  <= cap_d;
        rp_q   <= '0;
        wp_q   <= '0;
        used_q <= '0;
      end else if (accept_i) begin
        rp_q   <= rp_d;
        wp_q   <= wp_d;
        used_q <= used_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      meta_q <= meta_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_meta_o  = meta_q;

`ifndef SYNTHESIS
  a_used_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= cap_q)
    else $error("occupancy above capacity");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PTR_W'(wp_q - rp_q) == PTR_W'(used_q))
    else $error("pointer gap disagrees with occupancy");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> res_valid_q)
    else $error("accepted item gave no result");

  a_refused_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !cfg_we_i && (op == brb_pkg::OP_PUT) && !put_ok
      |=> $stable(wp_q) && $stable(used_q))
    else $error("refused put moved the write pointer");
`endif

endmodule

FILE: src/byte_ring_buffer_unit.sv
// top level of the byte ring buffer: control, banked store and read alignment
//
//  channel   signals                                      direction  accepted when
//  command   start_i, op_i, byte_count_i, write_data_i    in         start_i && !busy_o
//  result    result_valid_o, done_count_o, read_data_o,   out        every cycle it is high
//            free_bytes_o, used_bytes_o, is_empty_o, is_full_o
//  config    cfg_we_i, cfg_wdata_i                        in         cfg_we_i
//
//  one item per cycle; its result appears in the cycle after the accept edge,
//  set by the registered read of the eight byte banks
//  busy_o never rises: puts write and gets read the banks at the accept edge
//  reset clears both pointers and the occupancy and sets capacity to 1008 (at most depth - 16);
//  the store needs no clearing pass since only written bytes are ever read
//  the receiver cannot stall, results are a one-cycle strobe
module byte_ring_buffer_unit #(
  parameter int unsigned RING_DEPTH = brb_pkg::RING_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [1:0]                 op_i,
  input  logic [brb_pkg::CNT_W-1:0]  byte_count_i,
  input  logic [brb_pkg::DATA_W-1:0] write_data_i,
  input  logic                       cfg_we_i,
  input  logic [brb_pkg::CAP_W-1:0]  cfg_wdata_i,
  output logic                       result_valid_o,
  output logic [brb_pkg::CNT_W-1:0]  done_count_o,
  output logic [brb_pkg::DATA_W-1:0] read_data_o,
  output logic [brb_pkg::CAP_W-1:0]  free_bytes_o,
  output logic [brb_pkg::CAP_W-1:0]  used_bytes_o,
  output logic                       is_empty_o,
  output logic                       is_full_o
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned ROW_W = PTR_W - brb_pkg::LANE_W;
  localparam int unsigned ROWS  = RING_DEPTH / brb_pkg::NUM_LANES;
  localparam int unsigned NL    = brb_pkg::NUM_LANES;
  localparam int unsigned LW    = brb_pkg::LANE_W;

  logic [ROW_W-1:0]       lane_row [NL];
  logic [NL-1:0]          lane_we;
  logic [NL-1:0][7:0]     lane_wdata;
  logic [NL-1:0][7:0]     lane_rdata;
  logic                   lane_re;
  logic                   accept;
  logic                   res_valid;
  brb_pkg::res_meta_t     meta;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  brb_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .PTR_W      (PTR_W),
    .ROW_W      (ROW_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .op_i         (op_i),
    .byte_count_i (byte_count_i),
    .write_data_i (write_data_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .lane_row_o   (lane_row),
    .lane_we_o    (lane_we),
    .lane_wdata_o (lane_wdata),
    .lane_re_o    (lane_re),
    .res_valid_o  (res_valid),
    .res_meta_o   (meta)
  );

  for (genvar b = 0; b < NL; b++) begin : g_bank
    brb_bank_mem #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
    ) u_bank (
      .clk_i   (clk_i),
      .addr_i  (lane_row[b]),
      .we_i    (lane_we[b]),
      .wdata_i (lane_wdata[b]),
      .re_i    (lane_re),
      .rdata_o (lane_rdata[b])
    );
  end

  // byte i of a get comes from bank (rot + i) mod lanes; bytes past the count are zero
  for (genvar i = 0; i < NL; i++) begin : g_align
    logic [LW-1:0] src;
    assign src = meta.rot + LW'(i);
    assign read_data_o[8*i +: 8] =
      (meta.is_get && (brb_pkg::CNT_W'(i) < meta.done_count)) ? lane_rdata[src] : 8'h00;
  end

  assign result_valid_o = res_valid;
  assign done_count_o   = meta.done_count;
  assign free_bytes_o   = meta.free_bytes;
  assign used_bytes_o   = meta.used_bytes;
  assign is_empty_o     = meta.is_empty;
  assign is_full_o      = meta.is_full;

endmodule
